// ===== hw/rtl/chorus_pkg.sv =====
package chorus_pkg;

  localparam int DELAY_DEPTH_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int SINE_ENTRIES_DEF = 1024;

  localparam int BASE_W    = 12;
  localparam int MIX_W     = 16;
  localparam int PHASE_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SINE_W    = 16;

  // shared multiplier operand widths
  localparam int MA_W = 34;
  localparam int MB_W = 18;

  localparam int FRAC_W      = 30;
  localparam int ROUND_SHIFT = 16;
  localparam int WET_ONE     = 32768;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP   = 2'd3;

  localparam logic [MIX_W-1:0] WET_MIX_RESET = 16'd16384;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== hw/rtl/chorus_ram.sv =====
module chorus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/chorus_mul.sv =====
module chorus_mul import chorus_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [MA_W-1:0]        a,
  input  logic signed [MB_W-1:0]        b,
  output logic signed [MA_W+MB_W-1:0]   p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

// ===== hw/rtl/chorus_lfo.sv =====
module chorus_lfo import chorus_pkg::*; #(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [PHASE_W-1:0]       phase_step,
  output logic signed [SINE_W-1:0] sine
);

  localparam int LOGN    = $clog2(SINE_ENTRIES);
  localparam int QUARTER = SINE_ENTRIES / 4;
  localparam int QW      = LOGN - 2;

  // quarter wave in q2.30 with truncating taylor steps, rounded to q1.15
  function automatic logic [SINE_W-2:0] quarter_sine(input logic [63:0] r);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] p;
    logic [63:0] s;
    a  = (r * HALF_PI_Q30) / 64'(SINE_ENTRIES);
    a2 = (a * a) >> FRAC_W;
    p  = Q30_ONE - a2 / 64'd72;
    p  = Q30_ONE - ((a2 * p) >> FRAC_W) / 64'd42;
    p  = Q30_ONE - ((a2 * p) >> FRAC_W) / 64'd20;
    p  = Q30_ONE - ((a2 * p) >> FRAC_W) / 64'd6;
    s  = (a * p) >> FRAC_W;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[SINE_W-2:0];
  endfunction

  localparam logic [SINE_W-2:0] PEAK = quarter_sine(64'(SINE_ENTRIES));

  logic [SINE_W-2:0] rom [QUARTER];

  for (genvar g = 0; g < QUARTER; g++) begin : g_rom
    localparam logic [SINE_W-2:0] POINT = quarter_sine(64'(4 * g));
    assign rom[g] = POINT;
  end

  logic [PHASE_W-1:0] phase;
  logic [LOGN-1:0]    idx;
  logic [1:0]         quad;
  logic [QW-1:0]      fine;
  logic [QW-1:0]      rom_idx;
  logic               peak;
  logic [SINE_W-2:0]  mag;

  assign idx     = phase[PHASE_W-1 -: LOGN];
  assign quad    = idx[LOGN-1 -: 2];
  assign fine    = idx[QW-1:0];
  assign rom_idx = quad[0] ? QW'(-fine) : fine;
  assign peak    = quad[0] && (fine == '0);
  assign mag     = peak ? PEAK : rom[rom_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (advance) begin
      phase <= phase + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    sine <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// ===== hw/rtl/chorus_modulated_delay_core.sv =====
// chorus modulated delay core
//
// input channel: in_valid / in_ready with sample_in, one signed dry word per
// audio sample. output channel: out_valid / out_ready with sample_out, one
// saturated chorus word for every input word, in order.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// base_delay, 1 wet_mix, 2 mod_depth, 3 lfo_phase_step. cfg_ready is always
// high; write only while no word is in flight.
// timing: the sequencer steps through mod, dq, dly, addr, read, wet and done,
// passing four products through one shared multiplier and one read of the
// history ram. in_ready is high only in the idle state, so the block takes
// a new word only after the previous one has been committed.
// a finished word sits in the output register; the next word is accepted
// and computed meanwhile, and the sequencer waits in its last step while
// the output register is still full and out_ready is low.
// reset: histories read as zero until written (fill tracking, no clearing
// pass), write slot and lfo phase go to zero, registers to their defaults.
module chorus_modulated_delay_core import chorus_pkg::*; #(
  parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [PHASE_W-1:0]            cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int PW    = MA_W + MB_W;
  localparam int DQ_W  = BASE_W + MA_W;
  localparam int DL_W  = DQ_W - FRAC_W;
  localparam int DT_W  = SB + 17;
  localparam int ACC_W = SB + 19;
  localparam int Y_W   = ACC_W - ROUND_SHIFT;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_DQ   = 3'd2;
  localparam logic [2:0] ST_DLY  = 3'd3;
  localparam logic [2:0] ST_ADDR = 3'd4;
  localparam logic [2:0] ST_READ = 3'd5;
  localparam logic [2:0] ST_WET  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]             state;
  logic [2:0]             state_next;

  logic [BASE_W-1:0]      base_delay;
  logic [MIX_W-1:0]       wet_mix;
  logic [MIX_W-1:0]       mod_depth;
  logic [PHASE_W-1:0]     lfo_phase_step;

  logic signed [SB-1:0]   x_reg;
  logic                   far;
  logic [AW-1:0]          delay_lo;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          rd_addr_next;
  logic                   rd_ok;
  logic signed [DT_W-1:0] dry_term;
  logic [AW-1:0]          ws;
  logic                   full;

  logic signed [SINE_W-1:0] sine;
  logic                     commit;

  logic                   mul_en;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PW-1:0]   prod;

  logic signed [DQ_W-1:0] dq;
  logic signed [DQ_W-1:0] dq_rnd;
  logic                   dq_pos;
  logic [DL_W-1:0]        delay;
  logic                   too_far;
  logic [AW:0]            diff;

  logic [2*SB-1:0]         ram_rdata;
  logic signed [SB-1:0]    hist_dry;
  logic signed [SB-1:0]    hist_wet;
  logic signed [SB:0]      sum;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic [Y_W-1:0]          y_wide;
  logic                    fits;
  logic [SB-1:0]           y;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign commit    = (state == ST_DONE) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay     <= '0;
      wet_mix        <= WET_MIX_RESET;
      mod_depth      <= '0;
      lfo_phase_step <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_DELAY: base_delay     <= cfg_data[BASE_W-1:0];
        REG_WET_MIX:    wet_mix        <= cfg_data[MIX_W-1:0];
        REG_MOD_DEPTH:  mod_depth      <= cfg_data[MIX_W-1:0];
        REG_LFO_STEP:   lfo_phase_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    case (state)
      ST_IDLE: state_next = (in_valid && in_ready) ? ST_MOD : ST_IDLE;
      ST_MOD:  state_next = ST_DQ;
      ST_DQ:   state_next = ST_DLY;
      ST_DLY:  state_next = ST_ADDR;
      ST_ADDR: state_next = ST_READ;
      ST_READ: state_next = ST_WET;
      ST_WET:  state_next = ST_DONE;
      ST_DONE: state_next = commit ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  chorus_lfo #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_lfo (
    .clk       (clk),
    .rst       (rst),
    .advance   (commit),
    .phase_step(lfo_phase_step),
    .sine      (sine)
  );

  // shared multiplier operands
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_MOD: begin
        mul_en = 1'b1;
        mul_a  = {{(MA_W-MIX_W){1'b0}}, mod_depth};
        mul_b  = {{(MB_W-SINE_W){sine[SINE_W-1]}}, sine};
      end
      ST_DQ: begin
        mul_en = 1'b1;
        mul_a  = prod[MA_W-1:0];
        mul_b  = {{(MB_W-BASE_W){1'b0}}, base_delay};
      end
      ST_DLY: begin
        mul_en = 1'b1;
        mul_a  = {{(MA_W-SB){x_reg[SB-1]}}, x_reg};
        mul_b  = MB_W'(WET_ONE) - {{(MB_W-MIX_W){1'b0}}, wet_mix};
      end
      ST_WET: begin
        mul_en = 1'b1;
        mul_a  = {{(MA_W-SB-1){sum[SB]}}, sum};
        mul_b  = {{(MB_W-MIX_W){1'b0}}, wet_mix};
      end
      default: ;
    endcase
  end

  chorus_mul u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  // delay = round(base * (1 + depth * sine)), clamped below at zero
  assign dq      = $signed(prod[DQ_W-1:0])
                 + $signed({{(DQ_W-BASE_W-FRAC_W){1'b0}}, base_delay, {FRAC_W{1'b0}}});
  assign dq_rnd  = dq + (DQ_W'(1) << (FRAC_W - 1));
  assign dq_pos  = !dq[DQ_W-1] && (dq != '0);
  assign delay   = dq_pos ? dq_rnd[DQ_W-1:FRAC_W] : '0;
  assign too_far = {1'b0, delay} >= (DL_W+1)'(DELAY_DEPTH);

  assign diff         = {1'b0, ws} - {1'b0, delay_lo};
  assign rd_addr_next = far ? ws
                      : (diff[AW] ? AW'(diff + (AW+1)'(DELAY_DEPTH)) : diff[AW-1:0]);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_reg <= sample_in;
    end
    if (state == ST_DLY) begin
      far      <= too_far;
      delay_lo <= delay[AW-1:0];
    end
    if (state == ST_ADDR) begin
      rd_addr  <= rd_addr_next;
      rd_ok    <= full || (rd_addr_next < ws);
      dry_term <= prod[DT_W-1:0];
    end
  end

  chorus_ram #(
    .WIDTH(2 * SB),
    .DEPTH(DELAY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (commit),
    .waddr(ws),
    .wdata({x_reg, y}),
    .re   (state == ST_READ),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign hist_dry = ram_rdata[2*SB-1:SB];
  assign hist_wet = ram_rdata[SB-1:0];
  assign sum      = rd_ok ? ($signed({hist_dry[SB-1], hist_dry})
                           + $signed({hist_wet[SB-1], hist_wet})) : '0;

  // output = 2*(1-wet)*x + wet*(dry_hist + wet_hist), round half up, saturate
  assign acc    = $signed({{(ACC_W-DT_W-1){dry_term[DT_W-1]}}, dry_term, 1'b0})
                + $signed(prod[ACC_W-1:0]);
  assign rnd    = acc + (ACC_W'(1) << (ROUND_SHIFT - 1));
  assign y_wide = rnd[ACC_W-1:ROUND_SHIFT];
  assign fits   = (&y_wide[Y_W-1:SB-1]) || !(|y_wide[Y_W-1:SB-1]);
  assign y      = fits ? y_wide[SB-1:0] : {y_wide[Y_W-1], {(SB-1){~y_wide[Y_W-1]}}};

  // write slot and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      ws   <= '0;
      full <= 1'b0;
    end else if (commit) begin
      if (ws == AW'(DELAY_DEPTH - 1)) begin
        ws   <= '0;
        full <= 1'b1;
      end else begin
        ws <= ws + AW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      sample_out <= y;
    end
  end

  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid && (state == ST_IDLE))
    else $error("finished word not loaded into output register");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MOD) && !in_ready)
    else $error("accepted word did not start the sequence");

  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_READ) && rd_ok && !full) |-> (rd_addr < ws))
    else $error("history read of a slot never written");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import chorus_pkg::*;

  localparam int SW            = SAMPLE_BITS_DEF;
  localparam int DELAY         = DELAY_DEPTH_DEF;
  localparam int NSINE         = SINE_ENTRIES_DEF;
  localparam int IDLE_LIMIT    = 4000;
  localparam int REPORT_LIMIT  = 10;
  localparam int SWEEP_PHASES  = 12;
  localparam int SWEEP_WORDS   = 115;

  typedef logic signed [SW-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(SW-1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  word_t                sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  word_t                sample_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PHASE_W-1:0]   cfg_data = '0;

  // predictor copy of registers and state
  logic [BASE_W-1:0]  cfg_base  = '0;
  logic [MIX_W-1:0]   cfg_wet   = WET_MIX_RESET;
  logic [MIX_W-1:0]   cfg_depth = '0;
  logic [PHASE_W-1:0] cfg_step  = '0;
  word_t              dry_line  [DELAY] = '{default: '0};
  word_t              echo_line [DELAY] = '{default: '0};
  int                 head = 0;
  logic [PHASE_W-1:0] phase_acc = '0;

  word_t expected_samples [$];

  bit calm       = 1'b0;
  int stall_left = 0;
  int quiet      = 0;
  int errors     = 0;
  int reports    = 0;
  int n_words    = 0;
  int n_checked  = 0;
  int n_settings = 0;
  int n_far      = 0;
  int n_negative = 0;
  int n_clipped  = 0;

  chorus_modulated_delay_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // quarter wave sine in q1.15 from a polynomial in q2.30
  function automatic longint quarter_wave(input longint unsigned r);
    longint unsigned a, a2, p, s;
    a  = (r * HALF_PI_Q30) / NSINE;
    a2 = (a * a) >> 30;
    p  = Q30_ONE - a2 / 72;
    p  = Q30_ONE - ((a2 * p) >> 30) / 42;
    p  = Q30_ONE - ((a2 * p) >> 30) / 20;
    p  = Q30_ONE - ((a2 * p) >> 30) / 6;
    s  = (a * p) >> 30;
    s  = (s + (64'd1 << 14)) >> 15;
    if (s > 32767) s = 32767;
    return longint'(s);
  endfunction

  function automatic longint lfo_point(input logic [PHASE_W-1:0] ph);
    longint unsigned idx, pos, quad, r;
    longint          v;
    idx  = (longint'(ph) * NSINE) >> 32;
    pos  = idx * 4;
    quad = pos / NSINE;
    r    = pos - quad * NSINE;
    if (quad[0]) r = NSINE - r;
    v = quarter_wave(r);
    return quad[1] ? -v : v;
  endfunction

  // one chorus step: modulated tap, dry/wet blend, then history update
  function automatic word_t chorus_next(input word_t x);
    longint sine, modv, dq, lag, acc, y;
    int     rd;
    sine = lfo_point(phase_acc);
    modv = longint'(Q30_ONE) + longint'(cfg_depth) * sine;
    dq   = longint'(cfg_base) * modv;
    lag  = 0;
    if (dq > 0) lag = (dq + (longint'(1) << 29)) >>> 30;
    else if (dq < 0) n_negative++;
    if (lag >= DELAY) begin
      rd = head;
      n_far++;
    end else begin
      rd = int'((head + DELAY - lag) % DELAY);
    end
    acc = 2 * (WET_ONE - longint'(cfg_wet)) * longint'(x)
        + longint'(cfg_wet) * (longint'(echo_line[rd]) + longint'(dry_line[rd]));
    y = (acc + (longint'(1) << 15)) >>> ROUND_SHIFT;
    if (y > longint'(WORD_MAX)) begin
      y = longint'(WORD_MAX);
      n_clipped++;
    end
    if (y < longint'(WORD_MIN)) begin
      y = longint'(WORD_MIN);
      n_clipped++;
    end
    dry_line[head]  = x;
    echo_line[head] = y[SW-1:0];
    head            = (head + 1) % DELAY;
    phase_acc       = phase_acc + cfg_step;
    return y[SW-1:0];
  endfunction

  function automatic word_t pick_sample();
    case ($urandom_range(0, 15))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic drive_word(input word_t x);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_samples.push_back(chorus_next(x));
    n_words++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PHASE_W-1:0] value,
                           input bit junk);
    logic [PHASE_W-1:0] data;
    data = value;
    if (junk) begin
      case (idx)
        REG_BASE_DELAY:
          data[PHASE_W-1:BASE_W] = (PHASE_W-BASE_W)'($urandom());
        REG_WET_MIX, REG_MOD_DEPTH:
          data[PHASE_W-1:MIX_W]  = (PHASE_W-MIX_W)'($urandom());
        default: ;
      endcase
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_DELAY: cfg_base  = data[BASE_W-1:0];
      REG_WET_MIX:    cfg_wet   = data[MIX_W-1:0];
      REG_MOD_DEPTH:  cfg_depth = data[MIX_W-1:0];
      REG_LFO_STEP:   cfg_step  = data;
      default: ;
    endcase
  endtask

  // only called with no word in flight
  task automatic load_settings(input logic [PHASE_W-1:0] base, input logic [PHASE_W-1:0] wet,
                               input logic [PHASE_W-1:0] depth, input logic [PHASE_W-1:0] step,
                               input bit junk);
    write_reg(REG_BASE_DELAY, base, junk);
    write_reg(REG_WET_MIX, wet, junk);
    write_reg(REG_MOD_DEPTH, depth, junk);
    write_reg(REG_LFO_STEP, step, junk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // default registers: zero delay, half wet
  task automatic test_reset_state();
    drive_word(WORD_MAX);
    drive_word(WORD_MIN);
    drive_word('0);
    drive_word('1);
    drive_word(word_t'(1));
    drive_word(word_t'(24'h555555));
    drain();
  endtask

  task automatic test_register_extremes();
    // longest base, full swing, lfo in quarter turns: tap past the line end and at zero
    load_settings(32'd4095, 32'd32768, 32'd32768, 32'h4000_0000, 1'b0);
    drive_word(WORD_MAX);
    drive_word(WORD_MIN);
    drive_word(word_t'(24'h123456));
    drive_word(word_t'(-5));
    drain();
    // fully dry, swing past unity so the delay goes negative
    load_settings(32'd3, 32'd0, 32'd65535, 32'h4000_0000, 1'b0);
    repeat (4) drive_word(pick_sample());
    drain();
    // wet above one drives the output into saturation
    load_settings(32'd2, 32'd65535, 32'd0, 32'd0, 1'b0);
    drive_word(WORD_MAX);
    drive_word(WORD_MIN);
    drive_word(WORD_MIN);
    drive_word(WORD_MAX);
    drain();
    load_settings(32'd1, 32'd32768, 32'd0, 32'hFFFF_FFFF, 1'b1);
    drive_word(word_t'(1));
    drive_word('1);
    drive_word('0);
    drain();
  endtask

  task automatic test_random_sweep();
    logic [PHASE_W-1:0] base, wet, depth, step;
    for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
      calm = (ph >= SWEEP_PHASES - 2);
      case ($urandom_range(0, 5))
        0:       base = 0;
        1:       base = 4095;
        2, 3:    base = $urandom_range(1, 40);
        default: base = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 5))
        0:       wet = 0;
        1:       wet = 32768;
        2:       wet = 65535;
        3:       wet = $urandom_range(32769, 65535);
        default: wet = $urandom_range(0, 32768);
      endcase
      case ($urandom_range(0, 5))
        0:       depth = 0;
        1:       depth = 32768;
        2:       depth = 65535;
        3:       depth = $urandom_range(32769, 65535);
        default: depth = $urandom_range(0, 32768);
      endcase
      case ($urandom_range(0, 4))
        0:       step = 0;
        1:       step = 32'hFFFF_FFFF;
        2:       step = $urandom();
        default: step = $urandom_range(1, 32'h0400_0000);
      endcase
      load_settings(base, wet, depth, step, 1'($urandom_range(0, 1)));
      repeat (SWEEP_WORDS) drive_word(pick_sample());
      drain();
    end
  endtask

  // output stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (!rst && !calm && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(1, 13);
    end
  end

  always @(posedge clk) begin
    word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (reports < REPORT_LIMIT) begin
          reports++;
          $display("unexpected output word 0x%06h", sample_out);
        end
      end else begin
        want = expected_samples.pop_front();
        if (sample_out !== want) begin
          errors++;
          if (reports < REPORT_LIMIT) begin
            reports++;
            $display("sample_out mismatch on word %0d: expected %0d (0x%06h), got %0d (0x%06h)",
                     n_checked, want, want, sample_out, sample_out);
          end
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words outstanding", quiet,
               expected_samples.size());
      $display("** chorus_modulated_delay_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_register_extremes();
    test_random_sweep();
    repeat (24) @(posedge clk);
    errors += expected_samples.size();
    $display("%0d words sent and %0d checked across %0d register settings, %0d failures",
             n_words, n_checked, n_settings, errors);
    $display("taps past line end %0d, negative delays %0d, saturated outputs %0d",
             n_far, n_negative, n_clipped);
    if (errors == 0)
      $display("** chorus_modulated_delay_core: PASSED **");
    else
      $display("** chorus_modulated_delay_core: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/chorus_pkg.sv
hw/rtl/chorus_ram.sv
hw/rtl/chorus_mul.sv
hw/rtl/chorus_lfo.sv
hw/rtl/chorus_modulated_delay_core.sv
tb/sv/testbench.sv
